FILE: hdl/led_blink_breath_controller_core_assert.svh
// Assertion macros for the checker file of this block.
`ifndef LED_BLINK_BREATH_CONTROLLER_CORE_ASSERT_SVH
`define LED_BLINK_BREATH_CONTROLLER_CORE_ASSERT_SVH

// Plain property, sampled on the rising clock edge, off while reset is active.
`define LBBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Overlapping implication form of the above.
`define LBBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: hdl/lbbc_pkg.sv
package lbbc_pkg;

  localparam int unsigned BreathFullDef = 1000;
  localparam int unsigned PwmPeriodDef  = 20;
  localparam int unsigned FlashTicks    = 500;
  localparam int unsigned BreathStep    = 7;

  localparam int unsigned TICK_W     = 32;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned SEEN_W     = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 1'b1;

  // LED modes
  localparam logic [MODE_W-1:0] MODE_STEADY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FLASH  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BREATH = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HOLD   = 2'd3;

  // seen-mode value meaning that no mode has been seen since reset
  localparam logic [SEEN_W-1:0] SEEN_NONE = 3'd4;

  // 256^k mod p by repeated doubling, for elaboration-time weights
  function automatic int unsigned pow256_mod(int unsigned k, int unsigned p);
    int unsigned acc;
    acc = 1;
    for (int unsigned i = 0; i < k; i++) begin
      for (int unsigned j = 0; j < 8; j++) begin
        acc = acc * 2;
        if (acc >= p) begin
          acc = acc - p;
        end
      end
    end
    return acc;
  endfunction

endpackage

FILE: hdl/led_blink_breath_controller_core.sv
// Channel      | Direction | Payload
// -------------+-----------+---------------------------------------------
// s_axis       | in        | tdata[31:0] tick_now
// m_axis       | out       | tdata[0] led_lit, tdata[7:1] zero
// cfg          | in        | idx 0 led_enable, idx 1 mode select
//
// One tick sample per clock cycle sustained while m_axis is not stalled. After
// the input register, three stages reduce tick mod PWM_PERIOD
// (byte-weighted sum, reciprocal multiply, subtract), the fourth updates the
// LED state and loads the output register.
// Reset clears configuration and LED state at once; no clearing pass.
// Each stage only waits when the stage after it is full and stalled.
module led_blink_breath_controller_core
  import lbbc_pkg::*;
#(
  parameter int unsigned BREATH_FULL = BreathFullDef,
  parameter int unsigned PWM_PERIOD  = PwmPeriodDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [31:0]           s_axis_tdata_i,   // [31:0] tick_now
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [7:0]            m_axis_tdata_o,   // [0] led_lit, [7:1] zero
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned LVL_W  = $clog2(BREATH_FULL + 1);
  localparam int unsigned R_W    = $clog2(PWM_PERIOD);
  localparam int unsigned SUM_W  = $clog2(4 * 255 * (PWM_PERIOD - 1) + 1);
  localparam int unsigned K_SH   = SUM_W + R_W;
  localparam longint unsigned RECIP = ((64'd1 << K_SH) + PWM_PERIOD - 1) / PWM_PERIOD;
  localparam int unsigned M_W    = K_SH + 1;
  localparam int unsigned PROD_W = SUM_W + M_W;
  localparam int unsigned CMP_W  = $clog2(PWM_PERIOD * BREATH_FULL + 1);
  localparam int unsigned WGT0   = pow256_mod(0, PWM_PERIOD);
  localparam int unsigned WGT1   = pow256_mod(1, PWM_PERIOD);
  localparam int unsigned WGT2   = pow256_mod(2, PWM_PERIOD);
  localparam int unsigned WGT3   = pow256_mod(3, PWM_PERIOD);

  // configuration
  logic              led_enable_q;
  logic [MODE_W-1:0] mode_sel_q;

  // pipeline control
  logic v0_q, v1_q, v2_q, v3_q, out_valid_q;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;
  logic commit;

  // pipeline payload
  logic [TICK_W-1:0] tick0_q, tick1_q, tick2_q, tick3_q;
  logic [SUM_W-1:0]  sum1_q, sum2_q;
  logic [SUM_W-1:0]  quo2_q;
  logic [R_W-1:0]    rem3_q;
  logic              led_lit_q;

  // LED state
  logic [SEEN_W-1:0] seen_mode_q;
  logic [TICK_W-1:0] ref_tick_q, ref_tick_d;
  logic              flash_phase_q, flash_phase_d;
  logic [LVL_W-1:0]  breath_level_q, breath_level_d;
  logic              breath_rising_q, breath_rising_d;
  logic              lit_level_q, lit_level_d;

  // stage datapath
  logic [SUM_W-1:0]  sum_d;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  rem_full;

  // state update
  logic              mode_chg;
  logic [TICK_W-1:0] ref_base;
  logic              phase_base;
  logic [LVL_W-1:0]  lvl_base;
  logic [TICK_W-1:0] tick_diff;
  logic [LVL_W:0]    lvl_up;
  logic [LVL_W-1:0]  lvl_step;
  logic              rising_step;
  logic              tick_moved;
  logic [LVL_W-1:0]  lvl_adv;
  logic [CMP_W-1:0]  pwm_lhs, pwm_rhs;

  assign rdy_out = !out_valid_q || m_axis_tready_i;
  assign rdy3    = !v3_q || rdy_out;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign rdy0    = !v0_q || rdy1;
  assign commit  = v3_q && rdy_out;

  assign s_axis_tready_o = rdy0;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, led_lit_q};

  // tick mod PWM_PERIOD, stage 1: fold the bytes with weights 256^k mod P
  always_comb begin
    sum_d = SUM_W'(tick0_q[7:0])   * SUM_W'(WGT0)
          + SUM_W'(tick0_q[15:8])  * SUM_W'(WGT1)
          + SUM_W'(tick0_q[23:16]) * SUM_W'(WGT2)
          + SUM_W'(tick0_q[31:24]) * SUM_W'(WGT3);
  end

  // stage 2: quotient by reciprocal, exact for every folded sum
  assign prod = PROD_W'(sum1_q) * PROD_W'(RECIP);

  // stage 3: remainder
  assign rem_full = sum2_q - SUM_W'(quo2_q * SUM_W'(PWM_PERIOD));

  // stage 4: LED state update
  always_comb begin
    mode_chg   = {1'b0, mode_sel_q} != seen_mode_q;
    ref_base   = mode_chg ? tick3_q : ref_tick_q;
    phase_base = mode_chg ? 1'b0 : flash_phase_q;
    lvl_base   = mode_chg ? '0 : breath_level_q;
    tick_diff  = tick3_q - ref_base;

    // one breathing step along the triangle
    lvl_up      = {1'b0, lvl_base} + (LVL_W + 1)'(BreathStep);
    rising_step = breath_rising_q;
    if (breath_rising_q) begin
      if (lvl_up >= (LVL_W + 1)'(BREATH_FULL)) begin
        lvl_step    = LVL_W'(BREATH_FULL);
        rising_step = 1'b0;
      end else begin
        lvl_step = lvl_up[LVL_W-1:0];
      end
    end else begin
      if (lvl_base <= LVL_W'(BreathStep)) begin
        lvl_step    = '0;
        rising_step = 1'b1;
      end else begin
        lvl_step = lvl_base - LVL_W'(BreathStep);
      end
    end

    tick_moved = tick3_q != ref_base;
    lvl_adv    = tick_moved ? lvl_step : lvl_base;
    // rem < floor(lvl*P/FULL)  <=>  (rem+1)*FULL <= lvl*P
    pwm_lhs    = (CMP_W'(rem3_q) + CMP_W'(1)) * CMP_W'(BREATH_FULL);
    pwm_rhs    = CMP_W'(lvl_adv) * CMP_W'(PWM_PERIOD);

    ref_tick_d      = ref_base;
    flash_phase_d   = phase_base;
    breath_level_d  = lvl_base;
    breath_rising_d = breath_rising_q;
    lit_level_d     = lit_level_q;

    if (!led_enable_q) begin
      lit_level_d = 1'b0;
    end else begin
      case (mode_sel_q)
        MODE_STEADY: begin
          lit_level_d = 1'b1;
        end
        MODE_FLASH: begin
          if (tick_diff >= TICK_W'(FlashTicks)) begin
            ref_tick_d    = tick3_q;
            flash_phase_d = !phase_base;
            lit_level_d   = !phase_base;
          end
        end
        MODE_BREATH: begin
          if (tick_moved) begin
            ref_tick_d      = tick3_q;
            breath_level_d  = lvl_step;
            breath_rising_d = rising_step;
          end
          lit_level_d = pwm_lhs <= pwm_rhs;
        end
        default: begin
          // hold level
        end
      endcase
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_enable_q    <= 1'b0;
      mode_sel_q      <= MODE_STEADY;
      v0_q            <= 1'b0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      v3_q            <= 1'b0;
      out_valid_q     <= 1'b0;
      seen_mode_q     <= SEEN_NONE;
      ref_tick_q      <= '0;
      flash_phase_q   <= 1'b0;
      breath_level_q  <= '0;
      breath_rising_q <= 1'b1;
      lit_level_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ENABLE: led_enable_q <= cfg_wdata_i[0];
          REG_MODE:   mode_sel_q   <= cfg_wdata_i[MODE_W-1:0];
          default: ;
        endcase
      end
      if (rdy0) begin
        v0_q <= s_axis_tvalid_i;
      end
      if (rdy1) begin
        v1_q <= v0_q;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
      if (rdy3) begin
        v3_q <= v2_q;
      end
      if (rdy_out) begin
        out_valid_q <= v3_q;
      end
      if (commit) begin
        seen_mode_q     <= {1'b0, mode_sel_q};
        ref_tick_q      <= ref_tick_d;
        flash_phase_q   <= flash_phase_d;
        breath_level_q  <= breath_level_d;
        breath_rising_q <= breath_rising_d;
        lit_level_q     <= lit_level_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid_i) begin
      tick0_q <= s_axis_tdata_i;
    end
    if (rdy1 && v0_q) begin
      tick1_q <= tick0_q;
      sum1_q  <= sum_d;
    end
    if (rdy2 && v1_q) begin
      tick2_q <= tick1_q;
      sum2_q  <= sum1_q;
      quo2_q  <= prod[K_SH +: SUM_W];
    end
    if (rdy3 && v2_q) begin
      tick3_q <= tick2_q;
      rem3_q  <= rem_full[R_W-1:0];
    end
    if (commit) begin
      led_lit_q <= lit_level_d;
    end
  end

endmodule

FILE: hdl/lbbc_checker.sv
`include "led_blink_breath_controller_core_assert.svh"

module lbbc_checker
  import lbbc_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [7:0]            m_axis_tdata_o,   // [0] led_lit, [7:1] zero
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  logic              enable_q;
  logic [MODE_W-1:0] mode_q;

  // shadow of the configuration seen on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      mode_q   <= MODE_STEADY;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE: enable_q <= cfg_wdata_i[0];
        REG_MODE:   mode_q   <= cfg_wdata_i[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  `LBBC_ASSERT_IMPL(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, ##1 (m_axis_tvalid_o && $stable(m_axis_tdata_o)), "stalled result changed")
  `LBBC_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, m_axis_tvalid_o, m_axis_tdata_o[7:1] == 7'd0, "result padding not zero")
  `LBBC_ASSERT_IMPL(a_dark_off, clk_i, rst_ni, m_axis_tvalid_o && !enable_q, !m_axis_tdata_o[0], "LED lit while disabled")
  `LBBC_ASSERT_IMPL(a_steady_on, clk_i, rst_ni, m_axis_tvalid_o && enable_q && (mode_q == MODE_STEADY), m_axis_tdata_o[0], "LED dark in steady mode")

endmodule

bind led_blink_breath_controller_core lbbc_checker u_lbbc_checker (.*);
